### rtl/char_to_keycode_best_match_top_macros.svh
// assertion macros for the char to key code best match block
// clocked on clk; CKBM_ASSERT is disabled while arst_n is low, CKBM_ASSERT_ALWAYS is not; NO_ASSERTIONS removes them
`ifndef CHAR_TO_KEYCODE_BEST_MATCH_TOP_MACROS_SVH
`define CHAR_TO_KEYCODE_BEST_MATCH_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CKBM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CKBM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CKBM_ASSERT(lbl, prop, msg)
`define CKBM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/ckbm_pkg.sv
// shared types, constants and the entry scoring function
// used by the interfaces, the controller and the top level
`default_nettype none
package ckbm_pkg;

	localparam int LAYOUTS = 4;
	localparam int ENTRIES = 256;
	localparam int LAY_W   = 2;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int ADDR_W  = LAY_W + IDX_W;
	localparam int DEPTH   = LAYOUTS * ENTRIES;
	localparam int CP_W    = 21;
	localparam int KEY_W   = 8;
	localparam int WORD_W  = CP_W + KEY_W + 2;
	localparam int SCORE_W = 4;

	localparam logic [CP_W-1:0]  MAX_LOOKUP_CODE = CP_W'(21'h00FFFF);
	localparam logic [KEY_W-1:0] NUMPAD_LO = 8'h60;
	localparam logic [KEY_W-1:0] NUMPAD_HI = 8'h6F;
	localparam logic [KEY_W-1:0] OEM_LO    = 8'hBA;
	localparam logic [KEY_W-1:0] OEM_HI    = 8'hE2;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_REJECT   = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [SCORE_W-1:0] ckbm_score(input logic [KEY_W-1:0] key,
		input logic sh, input logic ag);
		logic [SCORE_W-1:0] s;
		s = SCORE_W'(2);
		if (!ag) s = s + SCORE_W'(4);
		if (!sh) s = s + SCORE_W'(2);
		if (key >= OEM_LO && key <= OEM_HI) s = s + SCORE_W'(1);
		if (key >= NUMPAD_LO && key <= NUMPAD_HI) s = s - SCORE_W'(2);
		return s;
	endfunction

endpackage
`default_nettype wire

### rtl/ckbm_req_if.sv
// request channel: valid/ready and the request payload
// depends on ckbm_pkg for field widths
`default_nettype none
interface ckbm_req_if
	import ckbm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [1:0]       req_type;
	logic [1:0]       layout;
	logic [CP_W-1:0]  codepoint;
	logic [KEY_W-1:0] entry_key_code;
	logic             entry_shift;
	logic             entry_altgr;

	modport source (output valid, req_type, layout, codepoint, entry_key_code,
		entry_shift, entry_altgr, input ready);
	modport sink (input valid, req_type, layout, codepoint, entry_key_code,
		entry_shift, entry_altgr, output ready);
endinterface
`default_nettype wire

### rtl/ckbm_rsp_if.sv
// response channel: valid/ready and the result payload
// depends on ckbm_pkg for field widths
`default_nettype none
interface ckbm_rsp_if
	import ckbm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [KEY_W-1:0] key_code;
	logic             shift_flag;
	logic             altgr_flag;

	modport source (output valid, status, key_code, shift_flag, altgr_flag,
		input ready);
	modport sink (input valid, status, key_code, shift_flag, altgr_flag,
		output ready);
endinterface
`default_nettype wire

### rtl/ckbm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module ckbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/ckbm_ctrl.sv
// request sequencer: table counts, append writes, lookup scan and result register
// depends on ckbm_pkg, the channel interfaces and the assertion macros
`default_nettype none
`include "char_to_keycode_best_match_top_macros.svh"
module ckbm_ctrl
	import ckbm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	ckbm_req_if.sink         req,
	ckbm_rsp_if.source       rsp,
	output mem_req_t         mem,
	input  wire logic [WORD_W-1:0] rdata
);
	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q [LAYOUTS];
	logic [LAY_W-1:0]   lay_q;
	logic [CP_W-1:0]    cp_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   last_q;
	logic               valid_s1;
	logic               seen_q;
	logic [SCORE_W-1:0] best_q;
	logic [KEY_W+1:0]   entry_q;
	status_t            res_q;
	logic               rsp_valid_q;
	status_t            rsp_status_q;
	logic [KEY_W-1:0]   rsp_key_q;
	logic               rsp_sh_q;
	logic               rsp_ag_q;

	logic               acc;
	logic               lay_ok;
	logic [CNT_W-1:0]   cnt_sel;
	logic               app_ok;
	logic [CP_W-1:0]    r_cp;
	logic [KEY_W-1:0]   r_key;
	logic               r_sh;
	logic               r_ag;
	logic [SCORE_W-1:0] r_score;
	logic               take;
	logic               load_rsp;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign lay_ok    = (32'(req.layout) < LAYOUTS);
	assign cnt_sel   = cnt_q[req.layout];
	assign app_ok    = lay_ok && (req.codepoint != '0) && (req.entry_key_code != '0)
		&& (cnt_sel < CNT_W'(ENTRIES));

	assign mem.we    = acc && (req.req_type == REQ_APPEND) && app_ok;
	assign mem.waddr = {req.layout, cnt_sel[IDX_W-1:0]};
	assign mem.wdata = {req.entry_altgr, req.entry_shift, req.entry_key_code, req.codepoint};
	assign mem.re    = (state_q == S_SCAN);
	assign mem.raddr = {lay_q, idx_q[IDX_W-1:0]};

	assign r_cp    = rdata[CP_W-1:0];
	assign r_key   = rdata[CP_W+KEY_W-1:CP_W];
	assign r_sh    = rdata[CP_W+KEY_W];
	assign r_ag    = rdata[CP_W+KEY_W+1];
	assign r_score = ckbm_score(r_key, r_sh, r_ag);
	assign take    = valid_s1 && (r_cp == cp_q) && (!seen_q || r_score > best_q);

	assign load_rsp = (state_q == S_FINISH) && (!rsp_valid_q || rsp.ready);

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.key_code   = rsp_key_q;
	assign rsp.shift_flag = rsp_sh_q;
	assign rsp.altgr_flag = rsp_ag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			for (int i = 0; i < LAYOUTS; i++) cnt_q[i] <= '0;
			lay_q        <= '0;
			cp_q         <= '0;
			idx_q        <= '0;
			last_q       <= '0;
			valid_s1     <= 1'b0;
			seen_q       <= 1'b0;
			best_q       <= '0;
			entry_q      <= '0;
			res_q        <= ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_OK;
			rsp_key_q    <= '0;
			rsp_sh_q     <= 1'b0;
			rsp_ag_q     <= 1'b0;
		end else begin
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			valid_s1 <= (state_q == S_SCAN);
			if (take) begin
				seen_q  <= 1'b1;
				best_q  <= r_score;
				entry_q <= {r_ag, r_sh, r_key};
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						lay_q   <= req.layout;
						cp_q    <= req.codepoint;
						idx_q   <= '0;
						last_q  <= cnt_sel - CNT_W'(1);
						seen_q  <= 1'b0;
						best_q  <= '0;
						entry_q <= '0;
						state_q <= S_FINISH;
						res_q   <= ST_OK;
						unique case (req.req_type)
							REQ_CLEAR: begin
								if (lay_ok) cnt_q[req.layout] <= '0;
							end
							REQ_APPEND: begin
								if (app_ok) cnt_q[req.layout] <= cnt_sel + CNT_W'(1);
								else res_q <= ST_REJECT;
							end
							REQ_LOOKUP: begin
								priority if (req.codepoint > MAX_LOOKUP_CODE) res_q <= ST_RANGE;
								else if (!lay_ok || cnt_sel == '0) res_q <= ST_NOTFOUND;
								else state_q <= S_SCAN;
							end
							default: res_q <= ST_OK;
						endcase
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + CNT_W'(1);
					if (idx_q == last_q) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					res_q   <= (seen_q || take) ? ST_OK : ST_NOTFOUND;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (load_rsp) begin
						rsp_status_q <= res_q;
						if (res_q == ST_OK) begin
							rsp_key_q <= entry_q[KEY_W-1:0];
							rsp_sh_q  <= entry_q[KEY_W];
							rsp_ag_q  <= entry_q[KEY_W+1];
						end else begin
							rsp_key_q <= '0;
							rsp_sh_q  <= 1'b0;
							rsp_ag_q  <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CKBM_ASSERT(a_write_only_on_append, mem.we |-> (acc && req.req_type == REQ_APPEND), "memory write outside an accepted append")
	`CKBM_ASSERT(a_count_bound, cnt_q[lay_q] <= CNT_W'(ENTRIES), "entry count above table size")
	`CKBM_ASSERT(a_read_data_from_scan, valid_s1 |-> $past(state_q == S_SCAN), "read data without a scan read")
	`CKBM_ASSERT(a_miss_has_no_key, (rsp.valid && rsp.status != ST_OK) |-> (rsp.key_code == '0 && !rsp.shift_flag && !rsp.altgr_flag), "key fields set on a failed result")
	`CKBM_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (state_q == S_IDLE && !rsp_valid_q), "not idle in reset")
endmodule
`default_nettype wire

### rtl/char_to_keycode_best_match_top.sv
// character to key code best match: 4 layouts x 256 entries in one 1024 x 31 ram
// clear, append, other codes and lookups without a scan: result beat with no ram read
// scanned lookup: one ram read per stored entry of the layout before the result beat
// one request at a time: ready again once the result is loaded; a stalled result holds it
// reset (arst_n low, asynchronous) empties all tables; ram contents need no clearing
// depends on ckbm_pkg, ckbm_req_if, ckbm_rsp_if, ckbm_ram and ckbm_ctrl
`default_nettype none
module char_to_keycode_best_match_top
	import ckbm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	ckbm_req_if.sink   req,
	ckbm_rsp_if.source rsp
);
	mem_req_t          mem;
	logic [WORD_W-1:0] rdata;

	ckbm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.mem    (mem),
		.rdata  (rdata)
	);

	ckbm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rdata)
	);
endmodule
`default_nettype wire
